>>> hw/rtl/graph_adjacency_store_defines.svh
// assertion macros shared by the graph adjacency store rtl
// no dependencies; taken in by the files that assert
`ifndef GRAPH_ADJACENCY_STORE_DEFINES_SVH
`define GRAPH_ADJACENCY_STORE_DEFINES_SVH

// condition implies check in the same cycle
`define GAS_ASSERT_NOW(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (check)) \
      else $error(msg);

// condition implies check in the next cycle
`define GAS_ASSERT_NEXT(label, clk, rst, cond, check, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (check)) \
      else $error(msg);

`endif

>>> hw/rtl/gas_pkg.sv
// types, codes and constants of the graph adjacency store
// no dependencies; used by controller, datapath and top level
package gas_pkg;

   localparam int MAX_VERTICES_DEF = 16;
   localparam int OP_W             = 2;
   localparam int KEY_W            = 32;
   localparam int WEIGHT_W         = 32;
   localparam int STATUS_W         = 2;
   localparam int DEGREE_W         = 5;

   localparam logic [WEIGHT_W-1:0] NO_EDGE = {WEIGHT_W{1'b1}};

   typedef enum logic [OP_W-1:0] {
      OP_ADD_VERTEX = 2'd0,
      OP_ADD_EDGE   = 2'd1,
      OP_DEGREE     = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MW_NONE,
      MW_CLEAR,
      MW_RC,
      MW_CR
   } mat_wr_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_SEARCH_A,
      S_SEARCH_B,
      S_WRITE_RC,
      S_WRITE_CR,
      S_ROW
   } state_type;

   typedef struct packed {
      logic       load;
      logic       key_write;
      logic       search_start;
      logic       search_step;
      logic       target_b;
      logic       save_r;
      logic       save_c;
      logic       row_step;
      mat_wr_type mat_wr;
      logic       respond;
      status_type rsp_status;
   } gas_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            hit;
      logic            miss;
      logic            row_done;
      logic            clear_last;
   } gas_stat_type;

endpackage

>>> hw/rtl/gas_datapath.sv
// datapath: request registers, key table, weight matrix, search and row scan
// depends on gas_pkg and graph_adjacency_store_defines.svh
`include "graph_adjacency_store_defines.svh"
module gas_datapath #(
   parameter int MAX_VERTICES = gas_pkg::MAX_VERTICES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [gas_pkg::OP_W-1:0]              req_operation,
   input  logic signed [gas_pkg::KEY_W-1:0]      req_vertex_key,
   input  logic signed [gas_pkg::KEY_W-1:0]      req_other_key,
   input  logic signed [gas_pkg::WEIGHT_W-1:0]   req_edge_weight,
   input  gas_pkg::gas_cmd_type                  cmd,
   output gas_pkg::gas_stat_type                 stat,
   output logic                                  rsp_strobe,
   output logic [gas_pkg::STATUS_W-1:0]          rsp_status,
   output logic [gas_pkg::DEGREE_W-1:0]          rsp_degree
);
   import gas_pkg::*;

   localparam int IW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int CELLS = MAX_VERTICES * MAX_VERTICES;
   localparam int AW    = $clog2(CELLS);

   logic [OP_W-1:0]            op_ff;
   logic signed [KEY_W-1:0]    key_a_ff;
   logic signed [KEY_W-1:0]    key_b_ff;
   logic signed [WEIGHT_W-1:0] weight_ff;

   logic signed [KEY_W-1:0]    key_mem [MAX_VERTICES];
   logic signed [KEY_W-1:0]    key_rdata_ff;
   logic [WEIGHT_W-1:0]        mat_mem [CELLS];
   logic [WEIGHT_W-1:0]        mat_rdata_ff;

   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [IW-1:0]       rd_idx_ff, rd_idx_in;
   logic [IW-1:0]       row_ff, col_ff;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [DEGREE_W-1:0] deg_ff, deg_in;

   logic                rsp_strobe_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [DEGREE_W-1:0] rsp_degree_ff;

   logic signed [KEY_W-1:0] target;
   logic [CW-1:0]           scan_limit;
   logic                    issue;
   logic                    match;
   logic                    mat_we;
   logic [AW-1:0]           mat_waddr;
   logic [AW-1:0]           mat_raddr;
   logic [WEIGHT_W-1:0]     mat_wdata;

   assign target     = cmd.target_b ? key_b_ff : key_a_ff;
   assign scan_limit = cmd.row_step ? CW'(MAX_VERTICES) : count_ff;
   assign issue      = (cmd.search_step || cmd.row_step) && (scan_ff < scan_limit);
   assign match      = rd_valid_ff && (key_rdata_ff == target);
   assign mat_raddr  = AW'(row_ff) * AW'(MAX_VERTICES) + AW'(scan_ff[IW-1:0]);

   always_comb begin
      count_in    = count_ff;
      scan_in     = scan_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      clr_in      = clr_ff;
      deg_in      = deg_ff;
      if (cmd.key_write) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.search_start) begin
         scan_in = '0;
      end else if (issue) begin
         rd_valid_in = 1'b1;
         rd_idx_in   = scan_ff[IW-1:0];
         scan_in     = scan_ff + CW'(1);
      end
      if (cmd.mat_wr == MW_CLEAR) begin
         clr_in = clr_ff + AW'(1);
      end
      // 5-bit count wraps for tables of more than 31 vertices
      if (cmd.load) begin
         deg_in = '0;
      end else if (cmd.row_step && rd_valid_ff && (mat_rdata_ff != NO_EDGE)) begin
         deg_in = deg_ff + DEGREE_W'(1);
      end
   end

   always_comb begin
      mat_we    = 1'b1;
      mat_waddr = clr_ff;
      mat_wdata = weight_ff;
      unique case (cmd.mat_wr)
         MW_CLEAR: begin
            mat_wdata = NO_EDGE;
         end
         MW_RC: begin
            mat_waddr = AW'(row_ff) * AW'(MAX_VERTICES) + AW'(col_ff);
         end
         MW_CR: begin
            mat_waddr = AW'(col_ff) * AW'(MAX_VERTICES) + AW'(row_ff);
         end
         default: begin
            mat_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         scan_ff       <= '0;
         rd_valid_ff   <= 1'b0;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         rd_valid_ff   <= rd_valid_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      deg_ff    <= deg_in;
      if (cmd.load) begin
         op_ff     <= req_operation;
         key_a_ff  <= req_vertex_key;
         key_b_ff  <= req_other_key;
         weight_ff <= req_edge_weight;
      end
      if (cmd.save_r) begin
         row_ff <= rd_idx_ff;
      end
      if (cmd.save_c) begin
         col_ff <= rd_idx_ff;
      end
      if (cmd.respond) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_degree_ff <= deg_ff;
      end
   end

   // key table
   always_ff @(posedge clock) begin
      if (cmd.key_write) begin
         key_mem[count_ff[IW-1:0]] <= key_a_ff;
      end
      key_rdata_ff <= key_mem[scan_ff[IW-1:0]];
   end

   // weight matrix
   always_ff @(posedge clock) begin
      if (mat_we) begin
         mat_mem[mat_waddr] <= mat_wdata;
      end
      mat_rdata_ff <= mat_mem[mat_raddr];
   end

   assign stat.op         = op_ff;
   assign stat.full       = (count_ff >= CW'(MAX_VERTICES));
   assign stat.hit        = match;
   assign stat.miss       = !rd_valid_ff && (scan_ff >= count_ff);
   assign stat.row_done   = !rd_valid_ff && (scan_ff >= CW'(MAX_VERTICES));
   assign stat.clear_last = (clr_ff == AW'(CELLS - 1));

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_degree = rsp_degree_ff;

   `GAS_ASSERT_NEXT(a_strobe_gap, clock, reset, rsp_strobe_ff, !rsp_strobe_ff, "back-to-back results")
   `GAS_ASSERT_NOW(a_write_room, clock, reset, cmd.key_write, count_ff < CW'(MAX_VERTICES), "key write into full table")
   `GAS_ASSERT_NOW(a_read_tagged, clock, reset, rd_valid_ff, $past(cmd.search_step || cmd.row_step), "read data without a step")

endmodule

>>> hw/rtl/gas_controller.sv
// controller state machine: sequences clearing, search, matrix writes, row scan
// depends on gas_pkg and graph_adjacency_store_defines.svh
`include "graph_adjacency_store_defines.svh"
module gas_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  gas_pkg::gas_stat_type stat,
   output gas_pkg::gas_cmd_type  cmd
);
   import gas_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.mat_wr = MW_CLEAR;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (stat.op)
               OP_ADD_VERTEX: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
                  if (stat.full) begin
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.key_write  = 1'b1;
                     cmd.rsp_status = ST_OK;
                  end
               end
               OP_ADD_EDGE, OP_DEGREE: begin
                  cmd.search_start = 1'b1;
                  state_in         = S_SEARCH_A;
               end
               default: begin
                  cmd.respond    = 1'b1;
                  cmd.rsp_status = ST_OK;
                  state_in       = S_IDLE;
               end
            endcase
         end
         S_SEARCH_A: begin
            priority if (stat.hit) begin
               cmd.save_r       = 1'b1;
               cmd.search_start = 1'b1;
               state_in         = (stat.op == OP_DEGREE) ? S_ROW : S_SEARCH_B;
            end else if (stat.miss) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_SEARCH_B: begin
            cmd.target_b = 1'b1;
            priority if (stat.hit) begin
               cmd.save_c = 1'b1;
               state_in   = S_WRITE_RC;
            end else if (stat.miss) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_NOT_FOUND;
               state_in       = S_IDLE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_WRITE_RC: begin
            cmd.mat_wr = MW_RC;
            state_in   = S_WRITE_CR;
         end
         S_WRITE_CR: begin
            // a self loop writes the same cell twice
            cmd.mat_wr     = MW_CR;
            cmd.respond    = 1'b1;
            cmd.rsp_status = ST_OK;
            state_in       = S_IDLE;
         end
         S_ROW: begin
            if (stat.row_done) begin
               cmd.respond    = 1'b1;
               cmd.rsp_status = ST_OK;
               state_in       = S_IDLE;
            end else begin
               cmd.row_step = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   `GAS_ASSERT_NEXT(a_resp_idle, clock, reset, cmd.respond, state_ff == S_IDLE, "no return to idle after result")
   `GAS_ASSERT_NOW(a_no_wr_in_search, clock, reset, cmd.mat_wr != MW_NONE, !cmd.search_step && !cmd.row_step, "matrix write during scan")
   `GAS_ASSERT_NEXT(a_load_dispatch, clock, reset, cmd.load, state_ff == S_DISPATCH && busy, "accepted beat not dispatched")

endmodule

>>> hw/rtl/graph_adjacency_store.sv
// Graph adjacency store: a vertex key table, a vertex count and a square
// matrix of 32-bit weights (all ones means no edge). A request beat is taken
// at a rising edge with start high and busy low; the result beat is shown on
// rsp_status and rsp_degree for one cycle with rsp_strobe high, and cannot be
// held off. After reset busy stays high while the matrix is cleared one
// word a cycle. Insert vertex writes the key unless the table is full;
// insert edge searches both keys, then writes the weight to both of
// their matrix cells; degree searches the key, then scans its row. A
// missing key ends the search with status not found. The key search and
// the row scan each read one word a cycle from their memory, and busy
// stays high for the whole operation.
// depends on gas_pkg, gas_controller and gas_datapath
module graph_adjacency_store #(
   parameter int MAX_VERTICES = gas_pkg::MAX_VERTICES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [gas_pkg::OP_W-1:0]            req_operation,
   input  logic signed [gas_pkg::KEY_W-1:0]    req_vertex_key,
   input  logic signed [gas_pkg::KEY_W-1:0]    req_other_key,
   input  logic signed [gas_pkg::WEIGHT_W-1:0] req_edge_weight,
   output logic                                rsp_strobe,
   output logic [gas_pkg::STATUS_W-1:0]        rsp_status,
   output logic [gas_pkg::DEGREE_W-1:0]        rsp_degree
);
   import gas_pkg::*;

   gas_cmd_type  cmd;
   gas_stat_type stat;

   gas_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   gas_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_operation),
      .req_vertex_key  (req_vertex_key),
      .req_other_key   (req_other_key),
      .req_edge_weight (req_edge_weight),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_degree      (rsp_degree)
   );

endmodule
